// File: rtl/wfeg_pkg.sv
// ----------------------------------------------------------------------------
// wfeg_pkg
// Shared types and constants for the wall follow error guard.
// ----------------------------------------------------------------------------
package wfeg_pkg;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_THRESHOLD   = 3'd0,
      CSR_RIGHT_THRESHOLD  = 3'd1,
      CSR_LEFT_REFERENCE   = 3'd2,
      CSR_RIGHT_REFERENCE  = 3'd3,
      CSR_LEFT_FALL_LIMIT  = 3'd4,
      CSR_RIGHT_FALL_LIMIT = 3'd5,
      CSR_GAIN             = 3'd6
   } csr_index_type;

   // per side fall counter
   localparam int                COUNT_W          = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 8'hFF;
   localparam logic [COUNT_W-1:0] FALL_LIMIT_RESET = 8'd3;

   // raised threshold offset while the guard holds
   localparam int GUARD_RAISE = 1000;

   localparam int GAIN_W = 16;

   // correction field
   localparam int                      CORR_W   = 29;
   localparam logic signed [CORR_W-1:0] CORR_MAX = {1'b0, {(CORR_W-1){1'b1}}};
   localparam logic signed [CORR_W-1:0] CORR_MIN = {1'b1, {(CORR_W-1){1'b0}}};

   // result beat layout
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 4;

   typedef enum logic [1:0] {
      WALL_BOTH       = 2'd0,
      WALL_NONE       = 2'd1,
      WALL_RIGHT_ONLY = 2'd2,
      WALL_LEFT_ONLY  = 2'd3
   } wall_case_type;

endpackage

// File: rtl/wall_follow_error_guard.sv
// ----------------------------------------------------------------------------
// wall_follow_error_guard
// Side-wall following error with anti-suction guard, times a Q4.12 gain.
// ----------------------------------------------------------------------------
// Takes one beat of left/right wall samples per cycle while the output side
// does not stall and returns one result beat per input beat, in order. Each
// beat passes through the stage-one register and then the output register.
// The first stage updates the per-side history (previous sample, fall count,
// guard) and forms the wall error; the second stage does the single signed
// multiply by the gain and saturates to 29 bits. The recurrence on the side
// history sets the rate of one beat per clock. Registers may be written only
// while no beat is in flight.
module wall_follow_error_guard
   import wfeg_pkg::*;
#(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   // csr write port
   input  logic                         csr_we,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata,
   // sample beats
   input  logic                         req_tvalid,
   output logic                         req_tready,
   // left_sample, right_sample
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // result beats
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // correction
   output logic [RSP_TDATA_W-1:0]       rsp_tdata,
   // wall_case, left_guard_on, right_guard_on
   output logic [RSP_TUSER_W-1:0]       rsp_tuser
);

   localparam int SB    = SAMPLE_BITS;
   localparam int EFF_W = ((SB > 10) ? SB : 10) + 1;
   localparam int ERR_W = SB + 2;
   localparam int PRD_W = ERR_W + GAIN_W;
   localparam int EXT_W = (PRD_W > CORR_W) ? PRD_W : CORR_W;

   // configuration registers
   logic [SB-1:0]             thr_ff     [2];
   logic [SB-1:0]             refr_ff    [2];
   logic [COUNT_W-1:0]        lim_ff     [2];
   logic signed [GAIN_W-1:0]  gain_ff;

   // side history
   logic [SB-1:0]             prev_ff    [2];
   logic [SB-1:0]             prev_in    [2];
   logic [COUNT_W-1:0]        count_ff   [2];
   logic [COUNT_W-1:0]        count_in   [2];
   logic                      guard_ff   [2];
   logic                      guard_in   [2];

   logic [SB-1:0]             samp       [2];
   logic                      seen       [2];
   logic [EFF_W-1:0]          eff        [2];
   logic signed [ERR_W-1:0]   dl, dr;

   // stage one
   logic                      s1_valid_ff, s1_valid_in;
   logic signed [ERR_W-1:0]   s1_err_ff, s1_err_in;
   wall_case_type             s1_case_ff, s1_case_in;
   logic [1:0]                s1_guard_ff;

   // output stage
   logic                      out_valid_ff, out_valid_in;
   logic signed [CORR_W-1:0]  out_corr_ff, out_corr_in;
   wall_case_type             out_case_ff;
   logic [1:0]                out_guard_ff;

   logic                      advance, req_fire;
   logic signed [PRD_W-1:0]   product;
   logic signed [EXT_W-1:0]   product_ext;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   assign samp[0] = req_tdata[SB-1:0];
   assign samp[1] = req_tdata[2*SB-1:SB];

   // per side history update
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         count_in[i] = count_ff[i];
         guard_in[i] = guard_ff[i];
         prev_in[i]  = samp[i];
         if (samp[i] <= prev_ff[i]) begin
            if (count_ff[i] != COUNT_MAX) begin
               count_in[i] = count_ff[i] + 1'b1;
            end
         end else if (samp[i] > thr_ff[i]) begin
            count_in[i] = '0;
            guard_in[i] = 1'b0;
         end
         if (count_in[i] > lim_ff[i]) begin
            guard_in[i] = 1'b1;
         end
         // raised threshold never wraps
         eff[i]  = guard_in[i] ? (EFF_W'(refr_ff[i]) + EFF_W'(GUARD_RAISE))
                               : EFF_W'(thr_ff[i]);
         seen[i] = EFF_W'(samp[i]) > eff[i];
      end
   end

   assign dl = signed'(ERR_W'(samp[0])) - signed'(ERR_W'(refr_ff[0]));
   assign dr = signed'(ERR_W'(samp[1])) - signed'(ERR_W'(refr_ff[1]));

   always_comb begin
      if (seen[0] && seen[1]) begin
         s1_err_in  = dl - dr;
         s1_case_in = WALL_BOTH;
      end else if (!seen[0] && !seen[1]) begin
         s1_err_in  = '0;
         s1_case_in = WALL_NONE;
      end else if (seen[1]) begin
         s1_err_in  = -(dr <<< 1);
         s1_case_in = WALL_RIGHT_ONLY;
      end else begin
         s1_err_in  = dl <<< 1;
         s1_case_in = WALL_LEFT_ONLY;
      end
   end

   assign s1_valid_in = (!s1_valid_ff || advance) ? req_fire : 1'b1;

   // multiply and saturate
   assign product     = s1_err_ff * gain_ff;
   assign product_ext = EXT_W'(product);

   always_comb begin
      if (product_ext > EXT_W'(CORR_MAX)) begin
         out_corr_in = CORR_MAX;
      end else if (product_ext < EXT_W'(CORR_MIN)) begin
         out_corr_in = CORR_MIN;
      end else begin
         out_corr_in = product_ext[CORR_W-1:0];
      end
   end

   assign out_valid_in = advance ? s1_valid_ff : out_valid_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0]  <= '0;
         thr_ff[1]  <= '0;
         refr_ff[0] <= '0;
         refr_ff[1] <= '0;
         lim_ff[0]  <= FALL_LIMIT_RESET;
         lim_ff[1]  <= FALL_LIMIT_RESET;
         gain_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT_THRESHOLD:   thr_ff[0]  <= csr_wdata[SB-1:0];
            CSR_RIGHT_THRESHOLD:  thr_ff[1]  <= csr_wdata[SB-1:0];
            CSR_LEFT_REFERENCE:   refr_ff[0] <= csr_wdata[SB-1:0];
            CSR_RIGHT_REFERENCE:  refr_ff[1] <= csr_wdata[SB-1:0];
            CSR_LEFT_FALL_LIMIT:  lim_ff[0]  <= csr_wdata[COUNT_W-1:0];
            CSR_RIGHT_FALL_LIMIT: lim_ff[1]  <= csr_wdata[COUNT_W-1:0];
            CSR_GAIN:             gain_ff    <= signed'(csr_wdata[GAIN_W-1:0]);
            default: ;
         endcase
      end
   end

   // side history and valids
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            prev_ff[i]  <= '0;
            count_ff[i] <= '0;
            guard_ff[i] <= 1'b0;
         end
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            for (int i = 0; i < 2; i++) begin
               prev_ff[i]  <= prev_in[i];
               count_ff[i] <= count_in[i];
               guard_ff[i] <= guard_in[i];
            end
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_err_ff   <= s1_err_in;
         s1_case_ff  <= s1_case_in;
         s1_guard_ff <= {guard_in[1], guard_in[0]};
      end
      if (advance && s1_valid_ff) begin
         out_corr_ff  <= out_corr_in;
         out_case_ff  <= s1_case_ff;
         out_guard_ff <= s1_guard_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(unsigned'(out_corr_ff));
   assign rsp_tuser  = {out_guard_ff, out_case_ff};

endmodule

// File: rtl/wfeg_checker.sv
// ----------------------------------------------------------------------------
// wfeg_checker
// Port-level checks for the wall follow error guard, bound to the top level.
// ----------------------------------------------------------------------------
module wfeg_checker
   import wfeg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tready,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [RSP_TUSER_W-1:0] rsp_tuser
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // input side never waits on an empty output
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

   // no wall means no correction
   a_no_wall_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == WALL_NONE) |-> (rsp_tdata == '0))
      else $error("nonzero correction with no wall seen");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind wall_follow_error_guard wfeg_checker u_wfeg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/wall_follow_error_guard_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_follow_error_guard_tb
// Self-checking bench for the wall follow error guard.
// ----------------------------------------------------------------------------
// Streams left/right wall sample pairs into the block and checks every result
// beat against an in-bench model of the side history, anti-suction guard,
// wall case selection and gain multiply. A short directed table comes first,
// then randomized falling/rising sample runs under several register settings,
// with source gaps, sink stalls, a long sink hold-off and a drain pause.
// ----------------------------------------------------------------------------
module wall_follow_error_guard_tb;
   import wfeg_pkg::*;

   localparam int SAMPLE_W    = 12;
   localparam int REQ_TDATA_W = ((2*SAMPLE_W+7)/8)*8;
   localparam int SAMPLE_TOP  = (1 << SAMPLE_W) - 1;
   localparam int SETTLE_CYCLES = 6;

   localparam int LEFT_SIDE  = 0;
   localparam int RIGHT_SIDE = 1;

   // register presets
   localparam int PRESET_KEEP       = -1;
   localparam int PRESET_MID        = 0;
   localparam int PRESET_LEFT_OPEN  = 1;
   localparam int PRESET_RIGHT_OPEN = 2;
   localparam int PRESET_SPREAD     = 3;
   localparam int PRESET_RANDOM     = 4;

   // sample run shapes for the random part
   localparam int RUN_FALL  = 0;
   localparam int RUN_RISE  = 1;
   localparam int RUN_NOISE = 2;
   localparam int RUN_HOLD  = 3;

   typedef struct {
      logic signed [CORR_W-1:0] correction;
      wall_case_type            wall_case;
      bit                       left_guard;
      bit                       right_guard;
   } steer_result_type;

   typedef struct {
      bit               typed;
      steer_result_type res;
   } pin_type;

   typedef struct {
      int            preset;
      int            left;
      int            right;
      bit            typed;
      wall_case_type wall_case;
      bit            left_guard;
      bit            right_guard;
   } dir_row_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_we;
   logic [CSR_IDX_W-1:0]     csr_index;
   logic [CSR_DATA_W-1:0]    csr_wdata;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata;   // left_sample, right_sample
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;   // correction
   logic [RSP_TUSER_W-1:0]   rsp_tuser;   // wall_case, left_guard_on, right_guard_on

   // model of the side history and registers
   int thr_cfg  [2];
   int ref_cfg  [2];
   int lim_cfg  [2];
   int prev_lvl [2];
   int fall_cnt [2];
   bit guard_on [2];
   longint gain_cfg;

   steer_result_type steer_due_q [$];
   pin_type          pinned_q [$];
   dir_row_type      dir_rows [$];

   int gen_last [2];
   int gen_kind [2];
   int gen_len  [2];

   int mismatch_count  = 0;
   int beats_checked   = 0;
   int settings_loaded = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int hold_cycles     = 0;

   wall_follow_error_guard #(
      .SAMPLE_BITS(SAMPLE_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("wall_follow_error_guard verification failed");
      $finish;
   end

   task automatic flag_mismatch(input string what);
      mismatch_count = mismatch_count + 1;
      $display("mismatch @%0t: %s", $time, what);
   endtask

   task automatic side_step(input int side, input int s, output bit seen);
      int eff;
      if (s <= prev_lvl[side]) begin
         if (fall_cnt[side] < int'(COUNT_MAX)) fall_cnt[side] = fall_cnt[side] + 1;
      end else if (s > thr_cfg[side]) begin
         fall_cnt[side] = 0;
         guard_on[side] = 1'b0;
      end
      if (fall_cnt[side] > lim_cfg[side]) guard_on[side] = 1'b1;
      prev_lvl[side] = s;
      eff = guard_on[side] ? ref_cfg[side] + GUARD_RAISE : thr_cfg[side];
      seen = s > eff;
   endtask

   task automatic predict_steer(input int l, input int r, output steer_result_type res);
      bit     l_seen;
      bit     r_seen;
      longint dl;
      longint dr;
      longint err;
      longint prod;
      side_step(LEFT_SIDE, l, l_seen);
      side_step(RIGHT_SIDE, r, r_seen);
      dl = longint'(l) - longint'(ref_cfg[LEFT_SIDE]);
      dr = longint'(r) - longint'(ref_cfg[RIGHT_SIDE]);
      if (l_seen && r_seen) begin
         err = dl - dr;
         res.wall_case = WALL_BOTH;
      end else if (!l_seen && !r_seen) begin
         err = 0;
         res.wall_case = WALL_NONE;
      end else if (r_seen) begin
         err = -2 * dr;
         res.wall_case = WALL_RIGHT_ONLY;
      end else begin
         err = 2 * dl;
         res.wall_case = WALL_LEFT_ONLY;
      end
      prod = err * gain_cfg;
      if (prod > longint'(CORR_MAX)) prod = longint'(CORR_MAX);
      if (prod < longint'(CORR_MIN)) prod = longint'(CORR_MIN);
      res.correction  = prod[CORR_W-1:0];
      res.left_guard  = guard_on[LEFT_SIDE];
      res.right_guard = guard_on[RIGHT_SIDE];
   endtask

   // the model follows register writes and beats at the same edges as the block
   always @(posedge clock) begin : beat_monitor
      steer_result_type due;
      steer_result_type got;
      pin_type          pin;
      if (reset) begin
         for (int s = LEFT_SIDE; s <= RIGHT_SIDE; s++) begin
            thr_cfg[s]  = 0;
            ref_cfg[s]  = 0;
            lim_cfg[s]  = int'(FALL_LIMIT_RESET);
            prev_lvl[s] = 0;
            fall_cnt[s] = 0;
            guard_on[s] = 1'b0;
         end
         gain_cfg = 0;
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_LEFT_THRESHOLD:   thr_cfg[LEFT_SIDE]  = int'(csr_wdata[SAMPLE_W-1:0]);
               CSR_RIGHT_THRESHOLD:  thr_cfg[RIGHT_SIDE] = int'(csr_wdata[SAMPLE_W-1:0]);
               CSR_LEFT_REFERENCE:   ref_cfg[LEFT_SIDE]  = int'(csr_wdata[SAMPLE_W-1:0]);
               CSR_RIGHT_REFERENCE:  ref_cfg[RIGHT_SIDE] = int'(csr_wdata[SAMPLE_W-1:0]);
               CSR_LEFT_FALL_LIMIT:  lim_cfg[LEFT_SIDE]  = int'(csr_wdata[COUNT_W-1:0]);
               CSR_RIGHT_FALL_LIMIT: lim_cfg[RIGHT_SIDE] = int'(csr_wdata[COUNT_W-1:0]);
               CSR_GAIN:             gain_cfg = longint'($signed(csr_wdata));
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_steer(int'(req_tdata[SAMPLE_W-1:0]),
                          int'(req_tdata[2*SAMPLE_W-1:SAMPLE_W]), due);
            if (pinned_q.size() != 0) begin
               pin = pinned_q.pop_front();
               if (pin.typed) due = pin.res;
            end
            steer_due_q.push_back(due);
         end
         if (rsp_tvalid && rsp_tready) begin
            beats_checked = beats_checked + 1;
            got.correction  = rsp_tdata[CORR_W-1:0];
            got.wall_case   = wall_case_type'(rsp_tuser[1:0]);
            got.left_guard  = rsp_tuser[2];
            got.right_guard = rsp_tuser[3];
            if (steer_due_q.size() == 0) begin
               flag_mismatch("result beat with no sample beat pending");
            end else begin
               due = steer_due_q.pop_front();
               if (got.correction !== due.correction)
                  flag_mismatch($sformatf("correction %0d, want %0d",
                                          got.correction, due.correction));
               if (got.wall_case !== due.wall_case)
                  flag_mismatch($sformatf("wall case %0d, want %0d",
                                          got.wall_case, due.wall_case));
               if (got.left_guard !== due.left_guard)
                  flag_mismatch($sformatf("left guard %0b, want %0b",
                                          got.left_guard, due.left_guard));
               if (got.right_guard !== due.right_guard)
                  flag_mismatch($sformatf("right guard %0b, want %0b",
                                          got.right_guard, due.right_guard));
            end
         end
      end
   end

   // sink side: random stalls plus an optional long hold-off
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles = hold_cycles - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic offer_pair(input int l, input int r);
      logic [SAMPLE_W-1:0] lv;
      logic [SAMPLE_W-1:0] rv;
      lv = SAMPLE_W'(l);
      rv = SAMPLE_W'(r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= REQ_TDATA_W'({rv, lv});
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      // let the monitor log the beat taken at this edge
      @(posedge clock);
      while (steer_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_config(input int lt, input int rt, input int lr, input int rr,
                               input int ll, input int rl, input int g);
      logic [CSR_DATA_W-1:0] vals [7];
      vals[CSR_LEFT_THRESHOLD]   = CSR_DATA_W'(lt);
      vals[CSR_RIGHT_THRESHOLD]  = CSR_DATA_W'(rt);
      vals[CSR_LEFT_REFERENCE]   = CSR_DATA_W'(lr);
      vals[CSR_RIGHT_REFERENCE]  = CSR_DATA_W'(rr);
      vals[CSR_LEFT_FALL_LIMIT]  = CSR_DATA_W'(ll);
      vals[CSR_RIGHT_FALL_LIMIT] = CSR_DATA_W'(rl);
      vals[CSR_GAIN]             = CSR_DATA_W'(g);
      for (int k = CSR_LEFT_THRESHOLD; k <= CSR_GAIN; k++) begin
         csr_we    <= 1'b1;
         csr_index <= csr_index_type'(k);
         csr_wdata <= vals[k];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      settings_loaded = settings_loaded + 1;
   endtask

   task automatic load_preset(input int preset);
      int lim_l;
      int lim_r;
      case (preset)
         PRESET_MID:        apply_config(2000, 2000, 2048, 2048, 3, 3, 4096);
         PRESET_LEFT_OPEN:  apply_config(0, SAMPLE_TOP, 0, SAMPLE_TOP, 0, 255, 32767);
         PRESET_RIGHT_OPEN: apply_config(SAMPLE_TOP, 0, SAMPLE_TOP, 0, 255, 0, -32768);
         PRESET_SPREAD:     apply_config(0, 0, 0, SAMPLE_TOP, 1, 1, -32768);
         default: begin
            // mostly short fall limits so the guard actually latches
            lim_l = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6);
            lim_r = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(6);
            apply_config($urandom_range(SAMPLE_TOP), $urandom_range(SAMPLE_TOP),
                         $urandom_range(SAMPLE_TOP), $urandom_range(SAMPLE_TOP),
                         lim_l, lim_r, $urandom_range(65535));
         end
      endcase
   endtask

   task automatic add_row(input int preset, input int l, input int r, input bit typed,
                          input wall_case_type wc, input bit lg, input bit rg);
      dir_row_type row;
      row.preset      = preset;
      row.left        = l;
      row.right       = r;
      row.typed       = typed;
      row.wall_case   = wc;
      row.left_guard  = lg;
      row.right_guard = rg;
      dir_rows.push_back(row);
   endtask

   // one side's next sample: falling runs latch the guard, rises clear it
   task automatic next_sample(input int side, output int v);
      int pick;
      if (gen_len[side] == 0) begin
         pick = $urandom_range(9);
         gen_kind[side] = (pick < 5) ? RUN_FALL : (pick < 8) ? RUN_RISE : RUN_NOISE;
         gen_len[side]  = $urandom_range(1, 12);
      end
      gen_len[side] = gen_len[side] - 1;
      case (gen_kind[side])
         RUN_FALL: v = gen_last[side] - $urandom_range(30);
         RUN_RISE: v = ($urandom_range(3) == 0) ? thr_cfg[side] + $urandom_range(1, 3)
                                              : gen_last[side] + $urandom_range(1, 400);
         RUN_HOLD: v = gen_last[side];
         default: begin
            pick = $urandom_range(5);
            if (pick < 3) v = $urandom_range(SAMPLE_TOP);
            else if (pick == 3) v = $urandom_range(1) ? SAMPLE_TOP : 0;
            else if (pick == 4) v = ref_cfg[side] + GUARD_RAISE + $urandom_range(4) - 2;
            else v = thr_cfg[side] + $urandom_range(4) - 2;
         end
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_TOP) v = SAMPLE_TOP;
      gen_last[side] = v;
   endtask

   initial begin : stimulus
      pin_type pin;
      int      n_items;
      int      preset;
      int      l;
      int      r;
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_LEFT_THRESHOLD;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      for (int s = LEFT_SIDE; s <= RIGHT_SIDE; s++) begin
         gen_last[s] = 0;
         gen_kind[s] = RUN_NOISE;
         gen_len[s]  = 0;
      end

      // after reset: zero thresholds and gain, fall limit three
      add_row(PRESET_KEEP, 0, 0, 1, WALL_NONE, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, SAMPLE_TOP, 1, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, 0, 1, WALL_LEFT_ONLY, 0, 0);
      add_row(PRESET_KEEP, 0, SAMPLE_TOP, 1, WALL_RIGHT_ONLY, 0, 0);
      add_row(PRESET_KEEP, 0, SAMPLE_TOP, 1, WALL_RIGHT_ONLY, 0, 0);
      // fourth non-rising left step in a row latches the left guard
      add_row(PRESET_KEEP, 0, SAMPLE_TOP, 1, WALL_RIGHT_ONLY, 1, 0);
      add_row(PRESET_KEEP, 1000, SAMPLE_TOP, 1, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 1000, SAMPLE_TOP, 1, WALL_BOTH, 0, 1);
      add_row(PRESET_KEEP, 1001, SAMPLE_TOP, 1, WALL_BOTH, 0, 1);
      // sample equal to the raised threshold is not a wall
      add_row(PRESET_KEEP, 1001, 1000, 1, WALL_LEFT_ONLY, 0, 1);
      add_row(PRESET_KEEP, 1001, 1001, 1, WALL_BOTH, 0, 0);
      // gain extremes and one-sided walls, model checked
      add_row(PRESET_LEFT_OPEN, SAMPLE_TOP, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 0, 0, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, 1, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 2048, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 1, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_RIGHT_OPEN, 0, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, 0, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 0, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_SPREAD, SAMPLE_TOP, 1, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, 1, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, SAMPLE_TOP, 0, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 0, SAMPLE_TOP, 0, WALL_BOTH, 0, 0);
      add_row(PRESET_KEEP, 1, 1, 0, WALL_BOTH, 0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < dir_rows.size(); i++) begin
         if (dir_rows[i].preset != PRESET_KEEP) begin
            wait_quiet();
            load_preset(dir_rows[i].preset);
         end
         pin.typed                = dir_rows[i].typed;
         pin.res.correction       = '0;
         pin.res.wall_case        = dir_rows[i].wall_case;
         pin.res.left_guard       = dir_rows[i].left_guard;
         pin.res.right_guard      = dir_rows[i].right_guard;
         pinned_q.push_back(pin);
         offer_pair(dir_rows[i].left, dir_rows[i].right);
      end

      for (int ph = 0; ph < 6; ph++) begin
         wait_quiet();
         n_items = 110;
         preset  = PRESET_RANDOM;
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  preset = PRESET_MID; end
            1: begin send_idle_pct = 61; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 61; end
            3: begin send_idle_pct = 30; stall_pct = 30; end
            4: begin send_idle_pct = 0;  stall_pct = 0;  n_items = 100; end
            default: begin
               send_idle_pct = 0;
               stall_pct     = 30;
               n_items       = 280;
               preset        = PRESET_RIGHT_OPEN;
            end
         endcase
         load_preset(preset);
         if (ph == 4) hold_cycles = 300;
         if (ph == 5) begin
            // flat left run long enough to pin the fall count at its ceiling
            gen_kind[LEFT_SIDE] = RUN_HOLD;
            gen_len[LEFT_SIDE]  = 270;
         end
         for (int n = 0; n < n_items; n++) begin
            if (ph == 4 && n == 60) wait_quiet();
            next_sample(LEFT_SIDE, l);
            next_sample(RIGHT_SIDE, r);
            offer_pair(l, r);
         end
      end

      wait_quiet();
      $display("checked %0d result beats over %0d register settings", beats_checked,
               settings_loaded);
      $display("with source gaps, sink stalls, a long sink hold-off and guard latching");
      if (mismatch_count == 0) begin
         $display("wall_follow_error_guard verification clean");
      end else begin
         $display("wall_follow_error_guard verification failed");
      end
      $finish;
   end

endmodule
